// ===== sv/merge_sort_engine_defines.svh =====
// Assertion macros for the merge sort engine.
// Depends on nothing; taken in by the top level with `include.
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every rising edge out of reset
`define MSE_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("merge sort engine: same-cycle check failed");

// next-cycle implication
`define MSE_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("merge sort engine: next-cycle check failed");

`else

`define MSE_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons)
`define MSE_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)

`endif

`endif

// ===== sv/mse_pkg.sv =====
// Shared constants, command/status types and element helpers for the merge sort engine.
// No dependencies; imported by the controller, the datapath and the top level.
package mse_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int DATA_WIDTH   = 32;
	localparam int TDATA_W      = 32;
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int SUM_W        = CNT_W + 2;

	typedef logic [DATA_WIDTH-1:0] elem_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // input transaction accepted
		logic sort_init;  // start sort: run 1, bank 0, lo 0, p 0
		logic seg_init;   // set up bounds of next run pair
		logic merge_wr;   // write one merged element
		logic pass_next;  // double run, flip banks
		logic emit_load;  // load output register with next sorted element
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic n_le1;      // set holds at most one element
		logic seg_end;    // this write finishes the run pair
		logic pass_end;   // run pair reaches end of set
		logic sort_end;   // doubled run covers the set
		logic emit_last;  // element being emitted is the final one
		logic out_free;   // output register can take a result
	} status_t;

	// low DATA_WIDTH bits of the input word, zero-extended when wider
	function automatic elem_t to_elem(input logic [TDATA_W-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[DATA_WIDTH-1:0];
	endfunction

	// element bits placed in the output word, zero-extended when narrower
	function automatic logic [TDATA_W-1:0] to_out(input elem_t e);
		logic [63:0] w;
		w = 64'(e);
		return w[TDATA_W-1:0];
	endfunction

endpackage

// ===== sv/mse_datapath.sv =====
// Datapath of the merge sort engine: ping-pong element memories, merge pointers,
// element count, overflow flag and the output register. Depends on mse_pkg.
module mse_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mse_pkg::cmd_t           cmd,
	output mse_pkg::status_t        st,
	input  logic [mse_pkg::TDATA_W-1:0] s_tdata,
	input  logic                    m_tready,
	output logic                    m_tvalid,
	output logic [mse_pkg::TDATA_W-1:0] m_tdata,
	output logic                    m_tlast,
	output logic                    m_tuser
);
	import mse_pkg::*;

	// two banks; a merge pass reads one and writes the other
	elem_t mem0 [MAX_ELEMENTS];
	elem_t mem1 [MAX_ELEMENTS];

	cnt_t  count_q;
	logic  dropped_q;
	cnt_t  run_q, lo_q, mid_q, hi_q, p_q, q_q, k_q;
	logic  bank_q;

	elem_t rd0a_q, rd0b_q, rd1a_q, rd1b_q;
	logic  m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [TDATA_W-1:0] m_tdata_q;

	elem_t a_data, b_data, wr_data;
	logic  take_left;
	logic [SUM_W-1:0] lo_run, lo_2run, run_2, n_ext;
	cnt_t  k_inc, p_inc;

	// operands of the current merge step
	always_comb begin
		a_data    = bank_q ? rd1a_q : rd0a_q;
		b_data    = bank_q ? rd1b_q : rd0b_q;
		take_left = (p_q < mid_q) && ((q_q >= hi_q) || ($signed(a_data) <= $signed(b_data)));
		wr_data   = take_left ? a_data : b_data;
		n_ext     = SUM_W'(count_q);
		lo_run    = SUM_W'(lo_q) + SUM_W'(run_q);
		run_2     = SUM_W'(run_q) << 1;
		lo_2run   = SUM_W'(lo_q) + run_2;
		k_inc     = k_q + cnt_t'(1);
		p_inc     = p_q + cnt_t'(1);
	end

	// status to the controller
	always_comb begin
		st.n_le1     = (count_q <= cnt_t'(1));
		st.seg_end   = (k_inc == hi_q);
		st.pass_end  = (hi_q == count_q);
		st.sort_end  = (run_2 >= n_ext);
		st.emit_last = (p_inc == count_q);
		st.out_free  = !m_tvalid_q || m_tready;
	end

	// memory writes and registered reads
	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < cnt_t'(MAX_ELEMENTS)))
			mem0[count_q[ADDR_W-1:0]] <= to_elem(s_tdata);
		else if (cmd.merge_wr && bank_q)
			mem0[k_q[ADDR_W-1:0]] <= wr_data;
		if (cmd.merge_wr && !bank_q)
			mem1[k_q[ADDR_W-1:0]] <= wr_data;
		rd0a_q <= mem0[p_q[ADDR_W-1:0]];
		rd0b_q <= mem0[q_q[ADDR_W-1:0]];
		rd1a_q <= mem1[p_q[ADDR_W-1:0]];
		rd1b_q <= mem1[q_q[ADDR_W-1:0]];
	end

	// count, flag and merge pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			run_q     <= '0;
			lo_q      <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			p_q       <= '0;
			q_q       <= '0;
			k_q       <= '0;
			bank_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (count_q < cnt_t'(MAX_ELEMENTS))
					count_q <= count_q + cnt_t'(1);
				else
					dropped_q <= 1'b1;
			end
			if (cmd.sort_init) begin
				run_q  <= cnt_t'(1);
				lo_q   <= '0;
				p_q    <= '0;
				bank_q <= 1'b0;
			end
			if (cmd.seg_init) begin
				mid_q <= (lo_run > n_ext) ? count_q : lo_run[CNT_W-1:0];
				hi_q  <= (lo_2run > n_ext) ? count_q : lo_2run[CNT_W-1:0];
				p_q   <= lo_q;
				q_q   <= (lo_run > n_ext) ? count_q : lo_run[CNT_W-1:0];
				k_q   <= lo_q;
			end
			if (cmd.merge_wr) begin
				k_q <= k_inc;
				if (take_left)
					p_q <= p_inc;
				else
					q_q <= q_q + cnt_t'(1);
				if (st.seg_end)
					lo_q <= hi_q;
			end
			if (cmd.pass_next) begin
				run_q  <= run_2[CNT_W-1:0];
				bank_q <= !bank_q;
				lo_q   <= '0;
				p_q    <= '0;
			end
			if (cmd.emit_load) begin
				p_q <= p_inc;
				if (st.emit_last) begin
					count_q   <= '0;
					dropped_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.emit_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			m_tdata_q <= to_out(a_data);
			m_tlast_q <= st.emit_last;
			m_tuser_q <= dropped_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== sv/mse_ctrl.sv =====
// Controller state machine of the merge sort engine: load, merge passes, emit.
// Depends on mse_pkg; drives the datapath through cmd_t and reads status_t.
module mse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tlast,
	output logic                s_tready,
	input  mse_pkg::status_t    st,
	output mse_pkg::cmd_t       cmd
);
	import mse_pkg::*;

	typedef enum logic [2:0] {
		S_LOAD, S_SORT_INIT, S_SEG, S_MRD, S_MWR, S_PASS, S_EMIT_RD, S_EMIT_OUT
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == S_LOAD);
	assign accept   = s_tvalid && s_tready;

	// commands decoded from the current state
	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.sort_init = (state_q == S_SORT_INIT);
		cmd.seg_init  = (state_q == S_SEG);
		cmd.merge_wr  = (state_q == S_MWR);
		cmd.pass_next = (state_q == S_PASS);
		cmd.emit_load = (state_q == S_EMIT_OUT) && st.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept && s_tlast)
						state_q <= S_SORT_INIT;
				end
				S_SORT_INIT: begin
					state_q <= st.n_le1 ? S_EMIT_RD : S_SEG;
				end
				S_SEG:  state_q <= S_MRD;
				S_MRD:  state_q <= S_MWR;
				S_MWR: begin
					if (!st.seg_end)
						state_q <= S_MRD;
					else if (st.pass_end)
						state_q <= S_PASS;
					else
						state_q <= S_SEG;
				end
				S_PASS: begin
					state_q <= st.sort_end ? S_EMIT_RD : S_SEG;
				end
				S_EMIT_RD: state_q <= S_EMIT_OUT;
				S_EMIT_OUT: begin
					if (st.out_free)
						state_q <= st.emit_last ? S_LOAD : S_EMIT_RD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ===== sv/merge_sort_engine.sv =====
// Merge sort engine: top level joining controller and datapath (mse_pkg, defines header).
// Input stream s_*: one signed element per transaction in s_tdata, s_tlast on the
// final element of a set. Up to 64 elements are kept; further ones are dropped and
// flag overflow on every result of that set. After the last element the set is
// sorted ascending by a stable bottom-up merge sort over two ping-pong memories.
// Output stream m_*: one sorted element per transaction, m_tlast on the final one,
// m_tuser set when elements were dropped.
// Sequence: loading takes an element on each transfer while s_tready is high; the
// SORT_INIT state then starts the sort. Each merge pass handles every element in two
// steps (registered memory read, then compare and write), plus one SEG step per run
// pair and one PASS step per pass; a set of n elements takes ceil(log2 n) passes.
// Emitting goes through a memory read step, then an output register load, per result.
// s_tready is high only while loading; a stalled m_tready holds the output register
// and the engine waits. The final result may still wait while the next set loads.
// Reset clears the count, flag and controller; memory contents are not cleared.
`include "merge_sort_engine_defines.svh"

module merge_sort_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [mse_pkg::TDATA_W-1:0]  s_tdata,   // [31:0] value
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [mse_pkg::TDATA_W-1:0]  m_tdata,   // [31:0] sorted_value
	output logic                         m_tlast,
	output logic                         m_tuser    // [0] overflow
);
	import mse_pkg::*;

	cmd_t    cmd;
	status_t st;

	mse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mse_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// output register is only loaded when it is free
	`MSE_ASSERT_IMPL(a_load_free, clk, arst_n, cmd.emit_load, st.out_free)
	// a transaction marked last stops loading and starts the sort
	`MSE_ASSERT_NEXT(a_last_sorts, clk, arst_n, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

// ===== tb/tb_merge_sort_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for merge_sort_engine: streams sets of signed elements,
// computes the sorted order of each set alongside and checks every output transaction.
// Depends on mse_pkg and the merge_sort_engine RTL.
module tb_merge_sort_engine;
	import mse_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 11;
	localparam int QUIET_LIMIT  = 20000;  // cycles with no transaction on either side
	localparam int RANDOM_ITEMS = 50;
	localparam int CALM_AFTER   = 30;     // random items sent before idling stops
	localparam int TAIL_CYCLES  = 64;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		elem_t value;
		logic  end_of_set;
		logic  overflow;
	} sorted_beat_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;    // [31:0] value
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;    // [31:0] sorted_value
	logic               m_tlast;
	logic               m_tuser;    // [0] overflow

	// set being loaded and the sorted beats still owed by the engine
	elem_t        loaded_set[$];
	logic         set_dropped;
	sorted_beat_t sorted_pending[$];

	int  mismatch_count;
	int  quiet_cycles;
	bit  idling_on;

	merge_sort_engine DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Load one element into the shadow set; on the last one, sort and queue the beats
	task automatic track_element(input elem_t value, input logic last);
		elem_t        ordered[$];
		elem_t        key;
		int           j;
		sorted_beat_t beat;
		begin
			if (loaded_set.size() < MAX_ELEMENTS)
				loaded_set.push_back(value);
			else
				set_dropped = 1'b1;
			if (!last)
				return;
			// stable insertion sort on signed keys
			ordered = loaded_set;
			for (int i = 1; i < ordered.size(); i++) begin
				key = ordered[i];
				j = i - 1;
				while (j >= 0 && $signed(ordered[j]) > $signed(key)) begin
					ordered[j + 1] = ordered[j];
					j--;
				end
				ordered[j + 1] = key;
			end
			for (int k = 0; k < ordered.size(); k++) begin
				beat.value      = ordered[k];
				beat.end_of_set = (k == ordered.size() - 1);
				beat.overflow   = set_dropped;
				sorted_pending.push_back(beat);
			end
			loaded_set.delete();
			set_dropped = 1'b0;
		end
	endtask

	// Drive one input transaction, with an optional idle burst ahead of it
	task automatic send_element(input elem_t value, input logic last);
		int gap;
		begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 15);
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= value;
			s_tlast  <= last;
			forever begin
				@(posedge clk);
				if (s_tready)
					break;
			end
			track_element(value, last);
		end
	endtask

	// Hold the input side until every owed result has come out
	task automatic wait_sorted_drained;
		begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			while (sorted_pending.size() != 0)
				@(posedge clk);
		end
	endtask

	function automatic elem_t random_value();
		case ($urandom_range(0, 3))
			0: return elem_t'($urandom_range(0, 8) - 4);          // dense range, many ties
			1: return $urandom_range(0, 1) ? elem_t'(32'h7FFF_FFFF - $urandom_range(0, 3))
				: elem_t'(32'h8000_0000 + $urandom_range(0, 3));
			default: return elem_t'($urandom());
		endcase
	endfunction

	// Extreme values, single and two element sets
	task automatic test_edge_values;
		begin
			send_element(32'h7FFF_FFFF, 1'b0);
			send_element(32'h8000_0000, 1'b0);
			send_element(32'h0000_0000, 1'b0);
			send_element(32'hFFFF_FFFF, 1'b0);
			send_element(32'h0000_0001, 1'b0);
			send_element(32'h8000_0000, 1'b0);
			send_element(32'h7FFF_FFFF, 1'b1);
			send_element(-32'sd5, 1'b1);
			send_element(32'd1, 1'b0);
			send_element(32'd0, 1'b1);
		end
	endtask

	// Equal keys spread over both halves of the merge
	task automatic test_ties;
		begin
			send_element(32'd3, 1'b0);
			send_element(32'd3, 1'b0);
			send_element(-32'sd3, 1'b0);
			send_element(32'd3, 1'b0);
			send_element(-32'sd3, 1'b0);
			send_element(32'd0, 1'b0);
			send_element(32'd0, 1'b1);
		end
	endtask

	// Exactly full store in reverse order: every pass does real work
	task automatic test_full_store;
		begin
			for (int i = 0; i < MAX_ELEMENTS; i++)
				send_element(elem_t'(1000 - 37 * i), i == MAX_ELEMENTS - 1);
		end
	endtask

	// Store full: extra elements dropped, last one among them; next set clean again
	task automatic test_overflow;
		begin
			for (int i = 0; i < MAX_ELEMENTS + 2; i++)
				send_element(random_value(), i == MAX_ELEMENTS + 1);
			send_element(32'd7, 1'b0);
			send_element(-32'sd7, 1'b0);
			send_element(32'd2, 1'b1);
		end
	endtask

	// Random sets, mostly short, now and then full or overflowing
	task automatic test_random_sets;
		int sent;
		int set_len;
		begin
			sent = 0;
			while (sent < RANDOM_ITEMS) begin
				case ($urandom_range(0, 19))
					0:       set_len = $urandom_range(60, 70);
					1, 2, 3: set_len = $urandom_range(11, 40);
					default: set_len = $urandom_range(1, 10);
				endcase
				for (int i = 0; i < set_len; i++) begin
					if (sent + i >= CALM_AFTER)
						idling_on = 1'b0;
					send_element(random_value(), i == set_len - 1);
				end
				sent += set_len;
			end
		end
	endtask

	// Reset and test sequence
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		set_dropped    = 1'b0;
		mismatch_count = 0;
		idling_on      = 1'b1;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_edge_values();
		test_ties();
		wait_sorted_drained();
		test_full_store();
		test_overflow();
		test_random_sets();

		wait_sorted_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Output ready with random stall bursts
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic note_mismatch(input string what, input sorted_beat_t want,
		input sorted_beat_t got);
		begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s: expected %0d last=%b ovf=%b, got %0d last=%b ovf=%b",
					$realtime, what, $signed(want.value), want.end_of_set, want.overflow,
					$signed(got.value), got.end_of_set, got.overflow);
		end
	endtask

	// Check each output transaction against the oldest owed beat
	always @(posedge clk) begin
		sorted_beat_t got;
		sorted_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.value      = m_tdata;
			got.end_of_set = m_tlast;
			got.overflow   = m_tuser;
			if (sorted_pending.size() == 0) begin
				want = '0;
				note_mismatch("unexpected result", want, got);
			end else begin
				want = sorted_pending.pop_front();
				if (got !== want)
					note_mismatch("wrong result", want, got);
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule
